### sv/sliding_window_minimum_unit_macros.svh
// ----------------------------------------------------------------------------
// Sliding window minimum unit: assertion macros
// Concurrent assertion shorthands used by the back end (swm_back.sv).
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MINIMUM_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MINIMUM_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SWM_ASSERT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define SWM_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

### sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window minimum package
// Shared constants for the sliding window minimum unit.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Default sizing
  localparam int unsigned MaxWindowDef   = 256;
  localparam int unsigned SampleWidthDef = 16;

  // Depth of the job queue between front and back end
  localparam int unsigned QueueDepthDef  = 2;

  // Configuration register
  localparam int unsigned WinLenW        = 9;
  localparam logic [WinLenW-1:0] WinLenReset = 9'd1;

  // APB port sizing and register map (index taken from paddr[2])
  localparam int unsigned ApbAddrW       = 3;
  localparam int unsigned ApbDataW       = 32;
  localparam logic        RegWindowLen   = 1'b0;

endpackage

### sv/sliding_window_minimum_unit.sv
// Path: an item that gives no result only writes its sample to history in the back
//   end; one that gives a result also walks the history (not for L = 1), passes the
//   finish state and loads the output register, L = window_len clamped to 1..MaxWindow.
// Throughput: a result item walks the single read port of the history RAM one entry per
//   cycle, taking no new item meanwhile; no-result items run at 1/cycle while idle.
// Reset (rst_ni low, async): fill count and write slot clear, window_len = 1,
//   queue and output empty. History RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// Sliding window minimum unit
// Minimum over the last window_len samples of a signed stream.
// ----------------------------------------------------------------------------
module sliding_window_minimum_unit import swm_pkg::*; #(
  parameter int unsigned MaxWindow   = MaxWindowDef,
  parameter int unsigned SampleWidth = SampleWidthDef,
  parameter int unsigned QueueDepth  = QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ApbAddrW-1:0]           paddr,
  input  logic [ApbDataW-1:0]           pwdata,
  output logic [ApbDataW-1:0]           prdata,
  output logic                          pready,

  // Sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic                          stream_start_i,

  // Result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SampleWidth-1:0] window_min_o
);

  localparam int unsigned AddrW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned LenW  = $clog2(MaxWindow + 1);
  // Queue word: sample, write slot, effective length, emit flag
  localparam int unsigned JobW  = SampleWidth + AddrW + LenW + 1;

  // --------------------------------------------------------------------------
  // Configuration register. Index is paddr[2]; only index 0 exists, so writes
  // to other words are dropped and read back as zero.
  // --------------------------------------------------------------------------
  logic [WinLenW-1:0] window_len_q;
  logic               reg_sel;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = (paddr[2] == RegWindowLen);
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WinLenReset;
    end else if (cfg_write) begin
      window_len_q <= pwdata[WinLenW-1:0];
    end
  end

  assign prdata = reg_sel ? ApbDataW'(window_len_q) : '0;

  // --------------------------------------------------------------------------
  // Front end: accepts an item per cycle when the queue has room, stamps it
  // with its history slot and effective window, and decides whether the
  // window is full enough to give a result.
  // --------------------------------------------------------------------------
  logic                          job_valid;
  logic                          job_ready;
  logic signed [SampleWidth-1:0] job_sample;
  logic [AddrW-1:0]              job_slot;
  logic [LenW-1:0]               job_len;
  logic                          job_emit;

  swm_front #(
    .MaxWindow   (MaxWindow),
    .SampleWidth (SampleWidth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .window_len_i   (window_len_q),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_i       (sample_i),
    .stream_start_i (stream_start_i),
    .job_valid_o    (job_valid),
    .job_ready_i    (job_ready),
    .job_sample_o   (job_sample),
    .job_slot_o     (job_slot),
    .job_len_o      (job_len),
    .job_emit_o     (job_emit)
  );

  // --------------------------------------------------------------------------
  // Job queue: decouples intake from the scan so the front keeps taking
  // items while the back end walks the history.
  // --------------------------------------------------------------------------
  logic [JobW-1:0] q_in_data;
  logic [JobW-1:0] q_out_data;
  logic            q_out_valid;
  logic            q_out_ready;

  assign q_in_data = {job_sample, job_slot, job_len, job_emit};

  swm_queue #(
    .DataW (JobW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (q_in_data),
    .pop_valid_o  (q_out_valid),
    .pop_ready_i  (q_out_ready),
    .pop_data_o   (q_out_data)
  );

  // --------------------------------------------------------------------------
  // Back end: writes each item's sample to history in queue order, then for
  // items that give a result reads the older job_len - 1 entries one per
  // cycle and keeps the running minimum. The result sits in an output
  // register until taken.
  // --------------------------------------------------------------------------
  logic signed [SampleWidth-1:0] bk_sample;
  logic [AddrW-1:0]              bk_slot;
  logic [LenW-1:0]               bk_len;
  logic                          bk_emit;

  assign {bk_sample, bk_slot, bk_len, bk_emit} = q_out_data;

  swm_back #(
    .MaxWindow   (MaxWindow),
    .SampleWidth (SampleWidth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_out_valid),
    .job_ready_o  (q_out_ready),
    .job_sample_i (bk_sample),
    .job_slot_i   (bk_slot),
    .job_len_i    (bk_len),
    .job_emit_i   (bk_emit),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .window_min_o (window_min_o)
  );

endmodule

### sv/swm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/swm_front.sv
// ----------------------------------------------------------------------------
// Sliding window minimum front end
// Takes samples, tracks write slot and fill count, classifies each item.
// ----------------------------------------------------------------------------
module swm_front import swm_pkg::*; #(
  parameter int unsigned MaxWindow   = MaxWindowDef,
  parameter int unsigned SampleWidth = SampleWidthDef,
  localparam int unsigned AddrW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1,
  localparam int unsigned LenW  = $clog2(MaxWindow + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [WinLenW-1:0]            window_len_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic                          stream_start_i,
  output logic                          job_valid_o,
  input  logic                          job_ready_i,
  output logic signed [SampleWidth-1:0] job_sample_o,
  output logic [AddrW-1:0]              job_slot_o,
  output logic [LenW-1:0]               job_len_o,
  output logic                          job_emit_o
);

  localparam logic [LenW-1:0]  MaxLen  = LenW'(MaxWindow);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(MaxWindow - 1);

  logic [AddrW-1:0] slot_q, slot_d;
  logic [LenW-1:0]  fill_q, fill_d;
  logic [LenW-1:0]  fill_base;
  logic [LenW-1:0]  eff_len;
  logic             accept;

  // Effective window: zero acts as one, clamp at the history depth.
  always_comb begin
    if (window_len_i == '0) begin
      eff_len = LenW'(1);
    end else if (32'(window_len_i) > 32'(MaxWindow)) begin
      eff_len = MaxLen;
    end else begin
      eff_len = LenW'(window_len_i);
    end
  end

  assign accept = in_valid_i & in_ready_o;

  always_comb begin
    fill_base = stream_start_i ? '0 : fill_q;
    fill_d    = (fill_base < MaxLen) ? fill_base + LenW'(1) : fill_base;
    slot_d    = (slot_q == LastSlot) ? '0 : slot_q + AddrW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
    end else if (accept) begin
      slot_q <= slot_d;
      fill_q <= fill_d;
    end
  end

  assign in_ready_o   = job_ready_i;
  assign job_valid_o  = in_valid_i;
  assign job_sample_o = sample_i;
  assign job_slot_o   = slot_q;
  assign job_len_o    = eff_len;
  assign job_emit_o   = (fill_d >= eff_len);

endmodule

### sv/swm_queue.sv
// ----------------------------------------------------------------------------
// Sliding window minimum job queue
// Small register FIFO between front and back end.
// ----------------------------------------------------------------------------
module swm_queue import swm_pkg::*; #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = QueueDepthDef,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [DataW-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [DataW-1:0] pop_data_o
);

  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [DataW-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### sv/swm_back.sv
// ----------------------------------------------------------------------------
// Sliding window minimum back end
// Stores each sample, scans the window in history, holds the result.
// ----------------------------------------------------------------------------
`include "sliding_window_minimum_unit_macros.svh"

module swm_back import swm_pkg::*; #(
  parameter int unsigned MaxWindow   = MaxWindowDef,
  parameter int unsigned SampleWidth = SampleWidthDef,
  localparam int unsigned AddrW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1,
  localparam int unsigned LenW  = $clog2(MaxWindow + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  input  logic signed [SampleWidth-1:0] job_sample_i,
  input  logic [AddrW-1:0]              job_slot_i,
  input  logic [LenW-1:0]               job_len_i,
  input  logic                          job_emit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SampleWidth-1:0] window_min_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [AddrW-1:0] LastSlot = AddrW'(MaxWindow - 1);

  logic [1:0]                    state_q, state_d;
  logic signed [SampleWidth-1:0] best_q, best_d;
  logic [AddrW-1:0]              addr_q, addr_d;
  logic [AddrW-1:0]              slot_q, slot_d;
  logic [LenW-1:0]               left_q, left_d;
  logic                          pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [SampleWidth-1:0] out_min_q, out_min_d;

  logic                          pop;
  logic                          issue;
  logic                          out_free;
  logic [AddrW-1:0]              prev_slot;
  logic [SampleWidth-1:0]        rdata;
  logic signed [SampleWidth-1:0] cand;

  swm_ram #(
    .Width (SampleWidth),
    .Depth (MaxWindow)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (pop),
    .waddr_i (job_slot_i),
    .wdata_i (job_sample_i),
    .re_i    (issue),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign job_ready_o = (state_q == ST_IDLE);
  assign pop         = job_valid_i & job_ready_o;
  assign issue       = (state_q == ST_SCAN) && (left_q != '0);
  assign out_free    = !out_valid_q || out_ready_i;
  assign prev_slot   = (job_slot_i == '0) ? LastSlot : job_slot_i - AddrW'(1);
  assign cand        = $signed(rdata);

  always_comb begin
    state_d     = state_q;
    best_d      = best_q;
    addr_d      = addr_q;
    slot_d      = slot_q;
    left_d      = left_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_min_d   = out_min_q;

    case (state_q)
      ST_IDLE: begin
        if (pop && job_emit_i) begin
          best_d = job_sample_i;
          slot_d = job_slot_i;
          if (job_len_i == LenW'(1)) begin
            state_d = ST_FIN;
          end else begin
            addr_d  = prev_slot;
            left_d  = job_len_i - LenW'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          addr_d = (addr_q == '0) ? LastSlot : addr_q - AddrW'(1);
          left_d = left_q - LenW'(1);
          pend_d = 1'b1;
        end
        if (pend_q && (cand < best_q)) begin
          best_d = cand;
        end
        if (!issue && pend_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_min_d   = best_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q    <= best_d;
    addr_q    <= addr_d;
    slot_q    <= slot_d;
    left_q    <= left_d;
    out_min_q <= out_min_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_min_o = out_min_q;

  // The scan never reaches back to the slot of the item being worked on.
  `SWM_ASSERT(a_scan_no_self, clk_i, rst_ni, !(issue && addr_q == slot_q), "scan wrapped onto own slot")
  // A compare is pending only while scanning.
  `SWM_ASSERT(a_pend_in_scan, clk_i, rst_ni, !(pend_q && state_q != ST_SCAN), "stray read compare")
  // Finishing with a free output register delivers the result next cycle.
  `SWM_ASSERT_NEXT(a_fin_load, clk_i, rst_ni, state_q == ST_FIN && out_free, out_valid_q && state_q == ST_IDLE, "result not loaded")

endmodule

### tb/sv/window_min_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window minimum checker
// Watches the config port and both item channels, keeps its own copy of the
// sample history and window length, predicts every window minimum and
// compares it with the item that leaves the block. Also checks register
// read-back.
// ----------------------------------------------------------------------------
module window_min_checker import swm_pkg::*; #(
  parameter int unsigned MaxWindow   = MaxWindowDef,
  parameter int unsigned SampleWidth = SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ApbAddrW-1:0]           paddr,
  input  logic [ApbDataW-1:0]           pwdata,
  input  logic [ApbDataW-1:0]           prdata,
  input  logic                          pready,

  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic                          stream_start_i,

  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SampleWidth-1:0] window_min_o,

  output int unsigned                   fail_count_o,
  output int unsigned                   mins_owed_o
);

  // shadow of the block state
  logic signed [SampleWidth-1:0] hist [MaxWindow];
  int unsigned                   wr_slot;
  int unsigned                   fill;
  logic [WinLenW-1:0]            win_len;

  logic signed [SampleWidth-1:0] expected_mins [$];
  logic signed [SampleWidth-1:0] new_min;
  logic signed [SampleWidth-1:0] want_min;
  int unsigned                   fails;

  assign fail_count_o = fails;
  assign mins_owed_o  = expected_mins.size();

  // Store one sample; returns 1 and the window minimum once the window is full.
  function automatic bit predict_window_min(input logic signed [SampleWidth-1:0] smp,
                                            input logic restart,
                                            output logic signed [SampleWidth-1:0] low);
    int unsigned span;
    int unsigned slot;
    int unsigned idx;
    int unsigned i;
    span = (win_len == 0) ? 1 : ((win_len > MaxWindow) ? MaxWindow : win_len);
    if (restart) fill = 0;
    slot = wr_slot;
    hist[slot] = smp;
    wr_slot = (slot + 1) % MaxWindow;
    if (fill < MaxWindow) fill++;
    low = smp;
    if (fill < span) return 1'b0;
    for (i = 1; i < span; i++) begin
      idx = (slot + MaxWindow - i) % MaxWindow;
      if (hist[idx] < low) low = hist[idx];
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot = 0;
      fill    = 0;
      win_len = WinLenReset;
      expected_mins.delete();
    end else begin
      if (psel && penable && pready && paddr[2] == RegWindowLen) begin
        if (pwrite) begin
          win_len = pwdata[WinLenW-1:0];
        end else if (prdata !== ApbDataW'(win_len)) begin
          $display("%0t window_len read: expected %0d, got %0d", $time, win_len, prdata);
          fails++;
        end
      end

      if (in_valid && in_ready) begin
        if (predict_window_min(sample_i, stream_start_i, new_min))
          expected_mins.push_back(new_min);
      end

      if (out_valid && out_ready) begin
        if (expected_mins.size() == 0) begin
          $display("%0t window_min: expected none, got %0d", $time, window_min_o);
          fails++;
        end else begin
          want_min = expected_mins.pop_front();
          if (window_min_o !== want_min) begin
            $display("%0t window_min: expected %0d, got %0d", $time, want_min, window_min_o);
            fails++;
          end
        end
      end
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window minimum unit testbench
// Drives sample streams through the block under a series of window lengths,
// with random gaps on the input and random back-pressure on the output.
// Prediction and comparison live in the checker; this module makes stimulus
// and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import swm_pkg::*;

  localparam int unsigned SW = SampleWidthDef;

  // Idle time after the last expected item: the back end may still be writing
  // history for queued items that give no result.
  localparam int unsigned SettleCycles = MaxWindowDef + 8;

  // Cycles with no handshake at all before the run is declared hung. The
  // slowest item (full window walk plus gap and stall) and the settle pause
  // both stay well below it.
  localparam int unsigned StallLimit = 3000;

  localparam logic [ApbAddrW-1:0] WinLenAddr = {RegWindowLen, 2'b00};

  localparam logic signed [SW-1:0] SmpMin = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SmpMax = {1'b0, {(SW-1){1'b1}}};

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;

  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [ApbAddrW-1:0]  paddr          = '0;
  logic [ApbDataW-1:0]  pwdata         = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic signed [SW-1:0] sample_i       = '0;
  logic                 stream_start_i = 1'b0;

  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic signed [SW-1:0] window_min_o;

  int unsigned          fail_count;
  int unsigned          mins_owed;

  // sender pacing: alternates between stretches with gaps and back-to-back bursts
  bit                   tx_calm        = 1'b0;
  int unsigned          tx_mode_left   = 20;
  logic signed [SW-1:0] drift_level    = '0;

  // receiver pacing, same idea
  bit                   rx_calm        = 1'b1;
  int unsigned          rx_mode_left   = 15;
  int unsigned          rx_hold        = 0;

  int unsigned          quiet_cycles   = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sliding_window_minimum_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_i       (sample_i),
    .stream_start_i (stream_start_i),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_min_o   (window_min_o)
  );

  window_min_checker u_min_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_i       (sample_i),
    .stream_start_i (stream_start_i),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_min_o   (window_min_o),
    .fail_count_o   (fail_count),
    .mins_owed_o    (mins_owed)
  );

  // Output back-pressure: after each accepted item, hold ready low for a random
  // draw (or not at all during a calm stretch).
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ready && out_valid) begin
        if (rx_mode_left == 0) begin
          rx_calm      = !rx_calm;
          rx_mode_left = $urandom_range(10, 60);
        end
        rx_mode_left--;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 5);
        if (rx_hold != 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        if (rx_hold <= 1) begin
          out_ready <= 1'b1;
          rx_hold = 0;
        end else begin
          rx_hold--;
        end
      end
    end
  end

  // Watchdog: any handshake on any port counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("sliding_window_minimum_unit: mismatch");
      $finish;
    end
  end

  // In half the draws a random walk so that minima age out of the window; some full-range
  // values and the two extremes mixed in.
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SmpMin;
      1:       return SmpMax;
      2, 3, 4: return SW'($urandom);
      default: begin
        drift_level += SW'($urandom_range(0, 128)) - SW'(64);
        return drift_level;
      end
    endcase
  endfunction

  // One APB transfer to the window length register: setup, access, then back to
  // idle so that back-to-back transfers never collide on the bus.
  task automatic apb_access(input logic wr, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WinLenAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write the window length with junk in the unused upper bits, then read back.
  task automatic set_window(input logic [WinLenW-1:0] win);
    logic [ApbDataW-1:0] word;
    word = $urandom;
    word[WinLenW-1:0] = win;
    apb_access(1'b1, word);
    apb_access(1'b0, '0);
  endtask

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_item(input logic signed [SW-1:0] smp, input logic restart);
    int unsigned gap;
    if (tx_mode_left == 0) begin
      tx_calm      = !tx_calm;
      tx_mode_left = $urandom_range(10, 60);
    end
    tx_mode_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    sample_i       <= smp;
    stream_start_i <= restart;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid, drain every expected item, then let the back end go quiet
  // so that the register may be written.
  task automatic settle();
    in_valid <= 1'b0;
    while (mins_owed != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // A phase at one window length: mostly whole streams long enough to give
  // results, with a rare stray restart. carry_on keeps the previous stream
  // going across the length change.
  task automatic run_phase(input logic [WinLenW-1:0] win, input int unsigned n_items,
                           input bit carry_on);
    int unsigned span;
    int unsigned left;
    logic        restart;
    span = (win == 0) ? 1 : ((win > MaxWindowDef) ? MaxWindowDef : win);
    set_window(win);
    left = carry_on ? $urandom_range(1, 2 * span) : 0;
    repeat (n_items) begin
      if (left == 0) begin
        left    = $urandom_range(span, 2 * span + 8);
        restart = 1'b1;
      end else begin
        restart = ($urandom_range(0, 2 * span + 30) == 0);
      end
      left--;
      send_item(pick_sample(), restart);
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the window length, then window 1: every item is its own
    // minimum; start flag on the very first item after reset
    apb_access(1'b0, '0);
    send_item(SmpMin, 1'b1);
    send_item(SmpMax, 1'b0);
    send_item('0, 1'b0);
    send_item(SW'(-1), 1'b0);
    send_item(SW'(1), 1'b0);
    send_item(SW'('h5555), 1'b0);
    send_item(SW'('hAAAA), 1'b0);
    send_item(SmpMax, 1'b1);
    settle();

    // zero length acts as a window of one
    set_window('0);
    send_item(SmpMin, 1'b0);
    send_item(SmpMax, 1'b0);
    send_item('0, 1'b1);
    settle();

    // window of two: extremes entering and leaving, restart drops the result
    set_window(9'd2);
    send_item(SmpMax, 1'b1);
    send_item(SmpMin, 1'b0);
    send_item(SmpMax, 1'b0);
    send_item(SmpMax, 1'b0);
    send_item(SW'(-1), 1'b0);
    send_item(SmpMin, 1'b1);
    settle();

    // random phases; over-range lengths saturate, length changes mid-stream
    run_phase(9'd511, 520, 1'b0);
    run_phase(9'd256, 200, 1'b1);
    run_phase(9'd300, 100, 1'b1);
    run_phase(9'd5,   150, 1'b1);
    run_phase(9'd2,   150, 1'b0);
    run_phase(9'd64,  160, 1'b0);
    run_phase(9'd1,    60, 1'b1);
    run_phase(9'd17,  150, 1'b0);
    run_phase(9'd8,   150, 1'b1);

    if (fail_count == 0 && mins_owed == 0)
      $display("sliding_window_minimum_unit: match");
    else
      $display("sliding_window_minimum_unit: mismatch");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/swm_pkg.sv
sv/swm_ram.sv
sv/swm_front.sv
sv/swm_queue.sv
sv/swm_back.sv
sv/sliding_window_minimum_unit.sv
tb/sv/window_min_checker.sv
tb/sv/tb_top.sv
